### design/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed in the next cycle");

`endif

### design/rme_pkg.sv
package rme_pkg;

  localparam int NUM_REGS  = 32;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 5;
  localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  localparam logic [2:0] CMD_MOV   = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_SUB   = 3'd2;
  localparam logic [2:0] CMD_MUL   = 3'd3;
  localparam logic [2:0] CMD_DIV   = 3'd4;
  localparam logic [2:0] CMD_PRINT = 3'd5;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_DIV0   = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

  function automatic logic reg_in_range(input logic [REG_IDX_W-1:0] idx);
    return {4'd0, idx} < 9'(NUM_REGS);
  endfunction

  function automatic logic [REG_AW-1:0] reg_addr(input logic [REG_IDX_W-1:0] idx);
    return REG_AW'(idx);
  endfunction

endpackage

### design/register_machine_execute_unit.sv
// Register machine execute unit.
// The input channel (in_valid_i / in_ready_o) carries one decoded instruction
// per request: MOV, ADD, SUB, MUL, DIV or PRINT with register or immediate
// sources. The output channel (out_valid_o / out_ready_i) carries one result
// for each PRINT and for each divide by zero, and nothing for other commands.
// in_ready_o is high only while no instruction is in flight. Each
// instruction reads its sources one at a time from a register file with a
// single read port; ADD, SUB, MUL and DIV by a nonzero divisor then run on
// one shared adder, MUL at one multiplier bit per cycle and DIV with a sign
// fix-up, one quotient bit per cycle and a final negate. The output register
// holds one finished result; while it waits, the next instruction is still
// taken, and a further result stalls the unit until the receiver takes the
// held one.
// Reset clears all 32 registers at once through per-entry valid bits, so
// the unit takes requests in the first cycle after reset.
module register_machine_execute_unit import rme_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  cmd_i,
  input  logic [REG_IDX_W-1:0]        dest_reg_i,
  input  logic                        a_is_reg_i,
  input  logic [REG_IDX_W-1:0]        a_reg_i,
  input  logic signed [DATA_W-1:0]    a_imm_i,
  input  logic                        b_is_reg_i,
  input  logic [REG_IDX_W-1:0]        b_reg_i,
  input  logic signed [DATA_W-1:0]    b_imm_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DATA_W-1:0]    print_value_o,
  output logic                        status_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_DISP = 3'd3;
  localparam logic [2:0] S_ALU  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [NUM_REGS-1:0]  valid_q;
  logic                 out_valid_q;

  logic [2:0]           cmd_q;
  logic [REG_IDX_W-1:0] dest_q, a_reg_q, b_reg_q;
  logic                 a_is_reg_q, b_is_reg_q;
  logic [DATA_W-1:0]    a_imm_q, b_imm_q;
  logic [DATA_W-1:0]    a_q;
  logic                 st_q;
  logic                 rd_ok_q;
  logic [DATA_W-1:0]    out_value_q;
  logic                 out_status_q;

  logic                 accept;
  logic                 out_free;
  logic [REG_IDX_W-1:0] rd_idx;
  logic [DATA_W-1:0]    ram_rdata, rd_val, b_val;
  logic                 b_zero;
  logic                 is_arith;
  logic                 we;
  logic [DATA_W-1:0]    wdata;
  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (state_q == S_RDA) begin
      rd_idx = (cmd_q == CMD_PRINT) ? dest_q : a_reg_q;
    end else begin
      rd_idx = b_reg_q;
    end
    // An entry not written since reset reads as zero, as does an index past the file.
    rd_val   = rd_ok_q ? ram_rdata : '0;
    b_val    = b_is_reg_q ? rd_val : b_imm_q;
    b_zero   = (b_val == '0);
    is_arith = cmd_q inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};

    alu_req.start = (state_q == S_DISP) && is_arith && !((cmd_q == CMD_DIV) && b_zero);
    case (cmd_q)
      CMD_ADD: alu_req.op = ALU_ADD;
      CMD_SUB: alu_req.op = ALU_SUB;
      CMD_MUL: alu_req.op = ALU_MUL;
      default: alu_req.op = ALU_DIV;
    endcase

    we = reg_in_range(dest_q) &&
         (((state_q == S_DISP) && (cmd_q == CMD_MOV)) ||
          ((state_q == S_ALU) && alu_rsp.done));
    wdata = (state_q == S_DISP) ? a_q : alu_rsp.result;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RDA;
        end
      end
      S_RDA: state_d = S_RDB;
      S_RDB: state_d = S_DISP;
      S_DISP: begin
        if (cmd_q == CMD_PRINT || ((cmd_q == CMD_DIV) && b_zero)) begin
          state_d = S_OUT;
        end else if (alu_req.start) begin
          state_d = S_ALU;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (we) begin
        valid_q[reg_addr(dest_q)] <= 1'b1;
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      dest_q     <= dest_reg_i;
      a_is_reg_q <= a_is_reg_i;
      a_reg_q    <= a_reg_i;
      a_imm_q    <= a_imm_i;
      b_is_reg_q <= b_is_reg_i;
      b_reg_q    <= b_reg_i;
      b_imm_q    <= b_imm_i;
    end
    rd_ok_q <= reg_in_range(rd_idx) && valid_q[reg_addr(rd_idx)];
    if (state_q == S_RDB) begin
      a_q <= (cmd_q == CMD_PRINT || a_is_reg_q) ? rd_val : a_imm_q;
    end
    if (state_q == S_DISP) begin
      if (cmd_q == CMD_PRINT) begin
        st_q <= STATUS_OK;
      end else begin
        a_q  <= '0;
        st_q <= STATUS_DIV0;
      end
    end
    if ((state_q == S_OUT) && out_free) begin
      out_value_q  <= a_q;
      out_status_q <= st_q;
    end
  end

  rme_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NUM_REGS)
  ) u_regfile (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(reg_addr(dest_q)),
    .wdata_i(wdata),
    .raddr_i(reg_addr(rd_idx)),
    .rdata_o(ram_rdata)
  );

  rme_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (a_q),
    .b_i   (b_val),
    .rsp_o (alu_rsp)
  );

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign print_value_o = out_value_q;
  assign status_o      = out_status_q;

endmodule

### design/rme_ram.sv
module rme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/rme_alu.sv
module rme_alu import rme_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alu_req_t          req_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output alu_rsp_t          rsp_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADDSUB = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_ABSA   = 3'd3;
  localparam logic [2:0] ST_ABSB   = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_FIX    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  localparam int CNT_W = $clog2(DATA_W);

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  alu_op_e           op_q;
  logic              neg_q;
  // x0: multiplicand or dividend/quotient, x1: multiplier or divisor,
  // acc: product accumulator or partial remainder, and finally the result.
  logic [DATA_W-1:0] x0_q, x1_q, acc_q;

  logic [DATA_W:0]   add_x, add_y, sum;
  logic              add_sub;

  // The single shared adder.
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      ST_ADDSUB: begin
        add_x   = {1'b0, x0_q};
        add_y   = {1'b0, x1_q};
        add_sub = (op_q == ALU_SUB);
      end
      ST_MUL: begin
        add_x = {1'b0, acc_q};
        add_y = {1'b0, x0_q};
      end
      ST_ABSA, ST_FIX: begin
        add_y   = {1'b0, x0_q};
        add_sub = 1'b1;
      end
      ST_ABSB: begin
        add_y   = {1'b0, x1_q};
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_x   = {acc_q, x0_q[DATA_W-1]};
        add_y   = {1'b0, x1_q};
        add_sub = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase
    sum = add_x + (add_sub ? ~add_y : add_y) + {{DATA_W{1'b0}}, add_sub};
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          cnt_d = CNT_W'(DATA_W - 1);
          case (req_i.op)
            ALU_ADD, ALU_SUB: state_d = ST_ADDSUB;
            ALU_MUL:          state_d = ST_MUL;
            default:          state_d = ST_ABSA;
          endcase
        end
      end
      ST_ADDSUB: state_d = ST_DONE;
      ST_MUL: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_ABSA: state_d = ST_ABSB;
      ST_ABSB: state_d = ST_DIV;
      ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX:  state_d = ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          x0_q  <= a_i;
          x1_q  <= b_i;
          acc_q <= '0;
          op_q  <= req_i.op;
          neg_q <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
        end
      end
      ST_ADDSUB: acc_q <= sum[DATA_W-1:0];
      ST_MUL: begin
        if (x1_q[0]) begin
          acc_q <= sum[DATA_W-1:0];
        end
        x0_q <= {x0_q[DATA_W-2:0], 1'b0};
        x1_q <= {1'b0, x1_q[DATA_W-1:1]};
      end
      ST_ABSA: begin
        if (x0_q[DATA_W-1]) begin
          x0_q <= sum[DATA_W-1:0];
        end
      end
      ST_ABSB: begin
        if (x1_q[DATA_W-1]) begin
          x1_q <= sum[DATA_W-1:0];
        end
      end
      ST_DIV: begin
        // Restoring step: keep the difference unless it went negative.
        if (!sum[DATA_W]) begin
          acc_q <= sum[DATA_W-1:0];
          x0_q  <= {x0_q[DATA_W-2:0], 1'b1};
        end else begin
          acc_q <= {acc_q[DATA_W-2:0], x0_q[DATA_W-1]};
          x0_q  <= {x0_q[DATA_W-2:0], 1'b0};
        end
      end
      ST_FIX: acc_q <= neg_q ? sum[DATA_W-1:0] : x0_q;
      default: begin
      end
    endcase
  end

  assign rsp_o.done   = (state_q == ST_DONE);
  assign rsp_o.result = acc_q;

endmodule

### design/rme_checker.sv
`include "assert_macros.svh"

module rme_checker import rme_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] print_value_o,
  input logic                     status_o
);

  // A held result stays offered until it is taken.
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable({print_value_o, status_o}))
  // Every instruction passes through the read states, so the unit is busy right after a request.
  `ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)
  // A divide by zero reports a zero value.
  `ASSERT_SAME(a_err_zero, out_valid_o && (status_o == STATUS_DIV0), print_value_o == '0)

endmodule

bind register_machine_execute_unit rme_checker u_rme_checker (.*);

### tb/tb_register_machine_execute_unit.sv
`timescale 1ns / 1ps

module tb_register_machine_execute_unit;
  import rme_pkg::*;

  // Opcodes that the unit must ignore.
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  localparam logic [DATA_W-1:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;

  typedef struct {
    logic [2:0]           cmd;
    logic [REG_IDX_W-1:0] dest;
    logic                 a_is_reg;
    logic [REG_IDX_W-1:0] a_reg;
    logic [DATA_W-1:0]    a_imm;
    logic                 b_is_reg;
    logic [REG_IDX_W-1:0] b_reg;
    logic [DATA_W-1:0]    b_imm;
  } instr_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              status;
  } print_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [2:0]               cmd_i = CMD_MOV;
  logic [REG_IDX_W-1:0]     dest_reg_i = '0;
  logic                     a_is_reg_i = 1'b0;
  logic [REG_IDX_W-1:0]     a_reg_i = '0;
  logic signed [DATA_W-1:0] a_imm_i = '0;
  logic                     b_is_reg_i = 1'b0;
  logic [REG_IDX_W-1:0]     b_reg_i = '0;
  logic signed [DATA_W-1:0] b_imm_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] print_value_o;
  logic                     status_o;

  logic [DATA_W-1:0] shadow_regs [NUM_REGS];
  print_result_t     pending_outputs [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int instrs_sent = 0;
  int results_checked = 0;
  int div0_seen = 0;

  register_machine_execute_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .dest_reg_i    (dest_reg_i),
    .a_is_reg_i    (a_is_reg_i),
    .a_reg_i       (a_reg_i),
    .a_imm_i       (a_imm_i),
    .b_is_reg_i    (b_is_reg_i),
    .b_reg_i       (b_reg_i),
    .b_imm_i       (b_imm_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .print_value_o (print_value_o),
    .status_o      (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Updates the shadow register file and queues the output the instruction causes.
  function automatic void execute_model(input instr_t it);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    longint            num;
    longint            den;
    print_result_t     res;
    a = it.a_is_reg ? shadow_regs[it.a_reg] : it.a_imm;
    b = it.b_is_reg ? shadow_regs[it.b_reg] : it.b_imm;
    case (it.cmd)
      CMD_MOV: shadow_regs[it.dest] = a;
      CMD_ADD: shadow_regs[it.dest] = a + b;
      CMD_SUB: shadow_regs[it.dest] = a - b;
      CMD_MUL: shadow_regs[it.dest] = a * b;
      CMD_DIV: begin
        if (b == '0) begin
          res.value = '0;
          res.status = STATUS_DIV0;
          pending_outputs = {pending_outputs, res};
        end else begin
          // Dividing in 64 bits makes INT_MIN / -1 wrap back to INT_MIN.
          num = longint'($signed(a));
          den = longint'($signed(b));
          shadow_regs[it.dest] = 32'(num / den);
        end
      end
      CMD_PRINT: begin
        res.value = shadow_regs[it.dest];
        res.status = STATUS_OK;
        pending_outputs = {pending_outputs, res};
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin : check_outputs
    print_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (status_o == STATUS_DIV0) div0_seen++;
      if (pending_outputs.size() == 0) begin
        $error("unexpected output: print_value %0d status %0d", print_value_o, status_o);
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (print_value_o !== want.value) begin
          $error("print_value: expected %0d, got %0d", $signed(want.value), print_value_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  function automatic instr_t instr(input logic [2:0] cmd, input int dest,
                                   input logic a_is_reg, input int a_reg,
                                   input logic [DATA_W-1:0] a_imm,
                                   input logic b_is_reg, input int b_reg,
                                   input logic [DATA_W-1:0] b_imm);
    instr_t it;
    it.cmd = cmd;
    it.dest = dest[REG_IDX_W-1:0];
    it.a_is_reg = a_is_reg;
    it.a_reg = a_reg[REG_IDX_W-1:0];
    it.a_imm = a_imm;
    it.b_is_reg = b_is_reg;
    it.b_reg = b_reg[REG_IDX_W-1:0];
    it.b_imm = b_imm;
    return it;
  endfunction

  // Immediates lean toward the values where arithmetic corners live.
  function automatic logic [DATA_W-1:0] rand_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = INT_MIN;
      2: v = INT_MAX;
      3: v = '1;
      4: v = $urandom_range(0, 20);
      5: v = -$urandom_range(1, 20);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic instr_t rand_instr();
    instr_t it;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 14)      it.cmd = CMD_MOV;
    else if (pick < 28) it.cmd = CMD_ADD;
    else if (pick < 40) it.cmd = CMD_SUB;
    else if (pick < 52) it.cmd = CMD_MUL;
    else if (pick < 70) it.cmd = CMD_DIV;
    else if (pick < 97) it.cmd = CMD_PRINT;
    else if (pick < 98) it.cmd = CMD_RSVD_A;
    else                it.cmd = CMD_RSVD_B;
    it.dest = REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
    it.a_is_reg = 1'($urandom_range(0, 1));
    it.a_reg = REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
    it.a_imm = rand_operand();
    it.b_is_reg = 1'($urandom_range(0, 1));
    it.b_reg = REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
    it.b_imm = rand_operand();
    return it;
  endfunction

  task automatic send_instr(input instr_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= it.cmd;
    dest_reg_i <= it.dest;
    a_is_reg_i <= it.a_is_reg;
    a_reg_i    <= it.a_reg;
    a_imm_i    <= it.a_imm;
    b_is_reg_i <= it.b_is_reg;
    b_reg_i    <= it.b_reg;
    b_imm_i    <= it.b_imm;
    do @(posedge clk_i); while (!in_ready_o);
    execute_model(it);
    instrs_sent++;
  endtask

  task automatic idle_sender();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_instr(rand_instr());
    idle_sender();
    wait_drain();
  endtask

  task automatic test_directed_arith();
    send_instr(instr(CMD_MOV, 0, 1'b0, 0, INT_MAX, 1'b0, 0, '0));
    send_instr(instr(CMD_MOV, 31, 1'b0, 0, INT_MIN, 1'b1, 31, '1));
    send_instr(instr(CMD_ADD, 1, 1'b1, 0, '0, 1'b0, 0, 32'd1));
    send_instr(instr(CMD_SUB, 2, 1'b1, 31, '0, 1'b0, 0, 32'd1));
    send_instr(instr(CMD_MUL, 3, 1'b1, 0, '0, 1'b1, 0, '0));
    send_instr(instr(CMD_DIV, 4, 1'b1, 31, '0, 1'b0, 0, '1));
    send_instr(instr(CMD_DIV, 5, 1'b0, 0, -32'sd7, 1'b0, 0, 32'd2));
    send_instr(instr(CMD_DIV, 6, 1'b0, 0, 32'd7, 1'b0, 0, -32'sd2));
    // MOV must ignore its second operand entirely.
    send_instr(instr(CMD_MOV, 8, 1'b1, 31, '1, 1'b0, 0, '1));
    idle_sender();
    wait_drain();
  endtask

  task automatic test_special_cases();
    int print_regs [10] = '{0, 1, 2, 3, 4, 5, 6, 8, 31, 9};
    // Divide by zero, once by an immediate and once by a cleared register.
    send_instr(instr(CMD_DIV, 4, 1'b0, 0, 32'd5, 1'b0, 0, '0));
    send_instr(instr(CMD_DIV, 4, 1'b0, 0, 32'd5, 1'b1, 7, '1));
    send_instr(instr(CMD_RSVD_A, 0, 1'b0, 0, '1, 1'b0, 0, '1));
    send_instr(instr(CMD_RSVD_B, 0, 1'b1, 31, '1, 1'b1, 31, '1));
    foreach (print_regs[k])
      send_instr(instr(CMD_PRINT, print_regs[k], 1'b0, 0, '0, 1'b0, 0, '0));
    idle_sender();
    wait_drain();
  endtask

  task automatic test_random_streaming();
    run_random(250, 0, 0);
  endtask

  task automatic test_random_sender_gaps();
    run_random(250, 71, 0);
  endtask

  task automatic test_random_receiver_stalls();
    run_random(250, 0, 71);
  endtask

  task automatic test_random_both_idle();
    run_random(250, 24, 24);
  endtask

  // Short bursts, each followed by a full stop until every output is back.
  task automatic test_pause_for_drain();
    for (int burst = 0; burst < 4; burst++) begin
      run_random(8, 0, 50);
      repeat (50) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_arith();
    test_special_cases();
    test_random_streaming();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();
    test_pause_for_drain();
    wait_drain();
    repeat (60) @(posedge clk_i);
    $display("Run covered %0d instructions and checked %0d outputs (%0d divide-by-zero).",
             instrs_sent, results_checked, div0_seen);
    $display("Directed corners plus random traffic under idle, gap, stall and drain mixes.");
    if (fail_count == 0 && pending_outputs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_outputs.size() != 0)
        $error("%0d expected outputs never arrived", pending_outputs.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/rme_pkg.sv
design/rme_ram.sv
design/rme_alu.sv
design/register_machine_execute_unit.sv
design/rme_checker.sv
tb/tb_register_machine_execute_unit.sv
